// File: sv/rkxh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rkxh_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [7:0] KEY_SUB = 8'd15;
  localparam logic [7:0] KEY_LENGTH_RESET = 8'd70;

  localparam int KEY_TEXT_LEN = 70;
  localparam logic [8*KEY_TEXT_LEN-1:0] KEY_TEXT =
    "89JFSjo8HUbhou5776NJOMp9i90ghg7Y78G78t68899y79HY7g7y87y9ED45Ew30O0jkkl";

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } req_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
    logic       error_flag;
  } rsp_item_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_length;
  } cfg_t;

  // Up to two results produced by one request
  typedef struct packed {
    logic [1:0] count;
    rsp_item_t  first;
    rsp_item_t  second;
  } res_t;

  // Built-in key: the key text, zero past its end
  function automatic logic [7:0] key_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (int'(idx) < KEY_TEXT_LEN) begin
      b = KEY_TEXT[(KEY_TEXT_LEN - 1 - int'(idx)) * 8 +: 8];
    end
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h61 + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  // {valid, value}; accepts either case
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/repeating_key_xor_hex_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request is coded as it loads into the result register, which waits while earlier
//   results are still held. Encrypt sends two hex characters per byte through the one result
//   port; decrypt takes one character per cycle while rsp_stall stays low.
// Reset (rst, synchronous, active high): mode encrypt, key length 70, key index 0, no
//   held nibble, input and result registers empty.
module repeating_key_xor_hex_codec #(
  parameter int KEY_DEPTH = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  rkxh_pkg::req_item_t              req_item,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output rkxh_pkg::rsp_item_t              rsp_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rkxh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rkxh_pkg::DATA_W-1:0] pwdata,
  output logic      [rkxh_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import rkxh_pkg::*;

  cfg_t      cfg;
  res_t      res;
  req_item_t ir_item;
  logic      ir_valid;
  logic      load_ok;
  logic      adv;
  logic      accept;

  assign adv       = ir_valid & load_ok;
  assign req_stall = ir_valid & ~load_ok;
  assign accept    = req_valid & ~req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (accept) begin
      ir_valid <= 1'b1;
    end else if (adv) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_item <= req_item;
    end
  end

  rkxh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rkxh_core #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (ir_item),
    .cfg  (cfg),
    .res  (res)
  );

  rkxh_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res       (res),
    .load_ok   (load_ok),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule
`default_nettype wire

// File: sv/rkxh_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module rkxh_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rkxh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rkxh_pkg::DATA_W-1:0] pwdata,
  output logic      [rkxh_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output rkxh_pkg::cfg_t                  cfg
);
  import rkxh_pkg::*;

  logic reg_idx;
  logic wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_ENCRYPT;
      cfg.key_length <= KEY_LENGTH_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_MODE:       cfg.mode       <= pwdata[0];
        REG_KEY_LENGTH: cfg.key_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:       prdata = {{(DATA_W-1){1'b0}}, cfg.mode};
      REG_KEY_LENGTH: prdata = {{(DATA_W-8){1'b0}}, cfg.key_length};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/rkxh_core.sv
`timescale 1ns / 1ps
`default_nettype none
module rkxh_core #(
  parameter int KEY_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  rkxh_pkg::req_item_t      item,
  input  rkxh_pkg::cfg_t           cfg,
  output rkxh_pkg::res_t           res
);
  import rkxh_pkg::*;

  localparam int IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [8:0] DEPTH_L = 9'(KEY_DEPTH);

  logic [IDX_W-1:0] key_index, key_index_next;
  logic [3:0]       pending_nibble, pending_nibble_next;
  logic             half_pair, half_pair_next;

  logic [7:0] key;
  logic [8:0] eff_len;
  logic [8:0] nx;
  logic [IDX_W-1:0] key_adv;
  logic [4:0] hv;
  logic [7:0] enc_b;
  logic [7:0] dec_b;

  assign key   = key_byte(8'(key_index));
  assign nx    = 9'(key_index) + 9'd1;
  assign hv    = hex_decode(item.data_in);
  assign enc_b = (item.data_in ^ key) - KEY_SUB;
  assign dec_b = ({pending_nibble, hv[3:0]} + KEY_SUB) ^ key;

  always_comb begin
    if (cfg.key_length == 8'd0) begin
      eff_len = 9'd1;
    end else if ({1'b0, cfg.key_length} > DEPTH_L) begin
      eff_len = DEPTH_L;
    end else begin
      eff_len = {1'b0, cfg.key_length};
    end
    key_adv = (nx >= eff_len) ? '0 : nx[IDX_W-1:0];
  end

  always_comb begin
    res                 = '0;
    key_index_next      = key_index;
    pending_nibble_next = pending_nibble;
    half_pair_next      = half_pair;
    if (cfg.mode == MODE_ENCRYPT) begin
      res.count         = 2'd2;
      res.first         = '{data_out: hex_char(enc_b[7:4]), last_out: 1'b0, error_flag: 1'b0};
      res.second        = '{data_out: hex_char(enc_b[3:0]), last_out: item.last_in,
                            error_flag: 1'b0};
      key_index_next    = key_adv;
    end else if (!hv[4]) begin
      // drop the character, keep any held nibble unless the message ends here
      res.count = 2'd1;
      res.first = '{data_out: 8'd0, last_out: item.last_in, error_flag: 1'b1};
    end else if (!half_pair) begin
      if (item.last_in) begin
        res.count = 2'd1;
        res.first = '{data_out: 8'd0, last_out: 1'b1, error_flag: 1'b1};
      end else begin
        pending_nibble_next = hv[3:0];
        half_pair_next      = 1'b1;
      end
    end else begin
      res.count           = 2'd1;
      res.first           = '{data_out: dec_b, last_out: item.last_in, error_flag: 1'b0};
      pending_nibble_next = 4'd0;
      half_pair_next      = 1'b0;
      key_index_next      = key_adv;
    end
    if (item.last_in) begin
      key_index_next      = '0;
      pending_nibble_next = 4'd0;
      half_pair_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_index      <= '0;
      pending_nibble <= 4'd0;
      half_pair      <= 1'b0;
    end else if (fire) begin
      key_index      <= key_index_next;
      pending_nibble <= pending_nibble_next;
      half_pair      <= half_pair_next;
    end
  end

`ifndef SYNTHESIS
  a_msg_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_in |=> key_index == '0 && !half_pair && pending_nibble == 4'd0)
    else $error("state not cleared after message end");

  a_encrypt_two: assert property (@(posedge clk) disable iff (rst)
    fire && cfg.mode == MODE_ENCRYPT |-> res.count == 2'd2)
    else $error("encrypt request must give two results");

  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    fire && res.count != 2'd0 && res.first.error_flag |-> res.first.data_out == 8'd0)
    else $error("error result carries data");

  a_pair_clears: assert property (@(posedge clk) disable iff (rst)
    fire && cfg.mode == MODE_DECRYPT && half_pair && hv[4] |=> !half_pair)
    else $error("held nibble not consumed");
`endif

endmodule
`default_nettype wire

// File: sv/rkxh_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
module rkxh_obuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  rkxh_pkg::res_t      res,
  output logic                load_ok,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rkxh_pkg::rsp_item_t rsp_item
);
  import rkxh_pkg::*;

  logic [1:0] cnt;
  rsp_item_t  slot0, slot1;
  logic       take;

  assign rsp_valid = (cnt != 2'd0);
  assign rsp_item  = slot0;
  assign take      = rsp_valid & ~rsp_stall;
  // free now, or free once the last held result leaves this cycle
  assign load_ok   = (cnt == 2'd0) || (cnt == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rkxh_pkg::*;

  localparam int KEY_DEPTH = 128;
  localparam logic [7:0] CIPHER_OFFSET = 8'd15;
  localparam string KEY_STR =
    "89JFSjo8HUbhou5776NJOMp9i90ghg7Y78G78t68899y79HY7g7y87y9ED45Ew30O0jkkl";
  localparam int SEG_ITEMS = 119;

  // one row of the directed table; also travels with each request as its note
  typedef struct packed {
    bit         cfg;
    logic       sel;
    logic [7:0] value;
    logic       last;
    logic       given;
    logic [1:0] n;
    rsp_item_t  r0;
    rsp_item_t  r1;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  repeating_key_xor_hex_codec #(.KEY_DEPTH(KEY_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // codec model state
  logic [7:0] key_rom [KEY_DEPTH];
  logic       cur_mode = MODE_ENCRYPT;
  logic [7:0] cur_klen = KEY_LENGTH_RESET;
  logic [6:0] key_pos = '0;
  logic [3:0] held_nib = '0;
  logic       held = 1'b0;

  rsp_item_t coded_q [$];
  step_t     req_plan_q [$];
  step_t     dir_tab [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  step_t     seen_note;
  int        got_n;
  rsp_item_t got_a, got_b, want;

  function automatic rsp_item_t rs(input logic [7:0] d, input logic l, input logic e);
    return {d, l, e};
  endfunction

  function automatic step_t rq(input logic [7:0] d, input logic l);
    step_t s;
    s = '0;
    s.value = d;
    s.last = l;
    return s;
  endfunction

  function automatic step_t rq_t(input logic [7:0] d, input logic l, input int n,
                                 input rsp_item_t a, input rsp_item_t b);
    step_t s;
    s = rq(d, l);
    s.given = 1'b1;
    s.n = 2'(n);
    s.r0 = a;
    s.r1 = b;
    return s;
  endfunction

  function automatic step_t wr(input logic sel, input logic [7:0] v);
    step_t s;
    s = '0;
    s.cfg = 1'b1;
    s.sel = sel;
    s.value = v;
    return s;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h57 + {4'h0, v};
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // take the key byte at the current position, then advance and wrap
  function automatic logic [7:0] next_key();
    int span;
    logic [7:0] k;
    span = (cur_klen == 8'd0) ? 1 : ((int'(cur_klen) > KEY_DEPTH) ? KEY_DEPTH : int'(cur_klen));
    k = key_rom[key_pos];
    key_pos = (int'(key_pos) + 1 >= span) ? 7'd0 : key_pos + 7'd1;
    return k;
  endfunction

  task automatic codec_predict(input req_item_t r, output int n,
                               output rsp_item_t a, output rsp_item_t b);
    logic [7:0] byte_v;
    int nib;
    n = 0;
    a = '0;
    b = '0;
    if (cur_mode == MODE_ENCRYPT) begin
      byte_v = (r.data_in ^ next_key()) - CIPHER_OFFSET;
      a = {nibble_char(byte_v[7:4]), 1'b0, 1'b0};
      b = {nibble_char(byte_v[3:0]), r.last_in, 1'b0};
      n = 2;
    end else begin
      nib = hex_value(r.data_in);
      if (nib < 0) begin
        // drop the character; a held nibble stays held unless the message ends here
        a = {8'h00, r.last_in, 1'b1};
        n = 1;
      end else if (!held) begin
        if (r.last_in) begin
          a = {8'h00, 1'b1, 1'b1};
          n = 1;
        end else begin
          held_nib = nib[3:0];
          held = 1'b1;
        end
      end else begin
        byte_v = ({held_nib, nib[3:0]} + CIPHER_OFFSET) ^ next_key();
        held = 1'b0;
        held_nib = '0;
        a = {byte_v, r.last_in, 1'b0};
        n = 1;
      end
    end
    if (r.last_in) begin
      key_pos = '0;
      held = 1'b0;
      held_nib = '0;
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    rsp_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        seen_note = (req_plan_q.size() != 0) ? req_plan_q.pop_front() : '0;
        codec_predict(req_item, got_n, got_a, got_b);
        if (seen_note.given) begin
          got_n = int'(seen_note.n);
          got_a = seen_note.r0;
          got_b = seen_note.r1;
        end
        if (got_n > 0) coded_q.push_back(got_a);
        if (got_n > 1) coded_q.push_back(got_b);
      end
      if (rsp_valid && !rsp_stall) begin
        if (coded_q.size() == 0) begin
          flag_error($sformatf("unexpected result data %02h last %0b err %0b",
                               rsp_item.data_out, rsp_item.last_out, rsp_item.error_flag));
        end else begin
          want = coded_q.pop_front();
          if (rsp_item.data_out !== want.data_out || rsp_item.last_out !== want.last_out ||
              rsp_item.error_flag !== want.error_flag) begin
            flag_error($sformatf(
              "result mismatch: expected data %02h last %0b err %0b, got %02h %0b %0b",
              want.data_out, want.last_out, want.error_flag,
              rsp_item.data_out, rsp_item.last_out, rsp_item.error_flag));
          end
        end
      end
    end
  end

  task automatic send_req(input step_t note);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_plan_q.push_back(note);
    req_valid <= 1'b1;
    req_item <= {note.value, note.last};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // drain: no request pending, no result outstanding, then let a held pair settle
  task automatic settle();
    req_valid <= 1'b0;
    while (coded_q.size() != 0 || req_plan_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [7:0] v);
    logic [7:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_MODE) cur_mode = v[0];
    else cur_klen = v;
    // read back the register just written
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = (sel == REG_MODE) ? {7'd0, prdata[0]} : prdata[7:0];
    if (rd !== ((sel == REG_MODE) ? {7'd0, v[0]} : v)) begin
      flag_error($sformatf("register %0d read back %02h, wrote %02h", sel, rd, v));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int len;
    int sent;
    int ph;
    int v;
    bit well;
    logic [7:0] ch;
    logic [7:0] near_hex [6];
    int klen_plan [16];

    for (int i = 0; i < KEY_DEPTH; i++) begin
      key_rom[i] = (i < KEY_STR.len()) ? KEY_STR[i] : 8'h00;
    end
    near_hex = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};
    klen_plan = '{1, 128, 2, 70, 1, 128, 3, 70, 0, 255, 127, 0, 5, 128, 1, 64};
    klen_plan[11] = $urandom_range(1, 128);

    dir_tab.push_back(rq_t(8'h00, 1'b0, 2, rs("2", 1'b0, 1'b0), rs("9", 1'b0, 1'b0)));
    dir_tab.push_back(rq_t(8'hff, 1'b1, 2, rs("b", 1'b0, 1'b0), rs("7", 1'b1, 1'b0)));
    dir_tab.push_back(rq_t(8'h38, 1'b1, 2, rs("f", 1'b0, 1'b0), rs("1", 1'b1, 1'b0)));
    dir_tab.push_back(wr(REG_MODE, MODE_DECRYPT));
    dir_tab.push_back(rq_t("z", 1'b0, 1, rs(8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(rq_t(8'h00, 1'b1, 1, rs(8'h00, 1'b1, 1'b1), '0));
    dir_tab.push_back(rq_t("2", 1'b1, 1, rs(8'h00, 1'b1, 1'b1), '0));
    dir_tab.push_back(rq_t("2", 1'b0, 0, '0, '0));
    dir_tab.push_back(rq_t("9", 1'b0, 1, rs(8'h00, 1'b0, 1'b0), '0));
    dir_tab.push_back(rq("B", 1'b0));
    dir_tab.push_back(rq_t("g", 1'b0, 1, rs(8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(rq_t("7", 1'b1, 1, rs(8'hff, 1'b1, 1'b0), '0));
    dir_tab.push_back(rq("F", 1'b0));
    dir_tab.push_back(wr(REG_MODE, MODE_ENCRYPT));
    dir_tab.push_back(rq(8'h5a, 1'b0));
    dir_tab.push_back(wr(REG_MODE, MODE_DECRYPT));
    dir_tab.push_back(rq("a", 1'b0));
    dir_tab.push_back(rq_t(8'hff, 1'b1, 1, rs(8'h00, 1'b1, 1'b1), '0));
    dir_tab.push_back(wr(REG_KEY_LENGTH, 8'd1));
    dir_tab.push_back(rq("f", 1'b0));
    dir_tab.push_back(rq_t("F", 1'b0, 1, rs(8'h36, 1'b0, 1'b0), '0));
    dir_tab.push_back(rq("f", 1'b0));
    dir_tab.push_back(rq_t("f", 1'b1, 1, rs(8'h36, 1'b1, 1'b0), '0));
    dir_tab.push_back(wr(REG_MODE, MODE_ENCRYPT));
    dir_tab.push_back(wr(REG_KEY_LENGTH, 8'd0));
    dir_tab.push_back(rq(8'h80, 1'b0));
    dir_tab.push_back(wr(REG_KEY_LENGTH, 8'd128));
    dir_tab.push_back(rq(8'h7f, 1'b0));
    dir_tab.push_back(wr(REG_KEY_LENGTH, 8'd1));
    dir_tab.push_back(rq(8'h01, 1'b1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) begin
        settle();
        reg_write(dir_tab[i].sel, dir_tab[i].value);
      end else begin
        send_req(dir_tab[i]);
      end
    end

    for (int seg = 0; seg < 16; seg++) begin
      settle();
      ph = seg % 4;
      idle_pct = (ph == 1) ? 65 : ((ph == 3) ? 16 : 0);
      stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 16 : 0);
      reg_write(REG_MODE, seg[2] ? MODE_DECRYPT : MODE_ENCRYPT);
      reg_write(REG_KEY_LENGTH, 8'(klen_plan[seg]));
      sent = 0;
      while (sent < SEG_ITEMS) begin
        if (cur_mode == MODE_ENCRYPT) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
          // end the segment on its item budget
          if (len > SEG_ITEMS - sent) len = SEG_ITEMS - sent;
          for (int j = 0; j < len; j++) begin
            send_req(rq(8'($urandom_range(255)), j == len - 1));
            sent++;
          end
        end else begin
          // mostly whole pairs; the rest any count from 1 to 15, and stray characters in both
          well = $urandom_range(99) < 85;
          if (well) begin
            len = 2 * (($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8));
          end else begin
            len = $urandom_range(1, 15);
          end
          if (len > SEG_ITEMS - sent) len = SEG_ITEMS - sent;
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(99) < (well ? 97 : 70)) begin
              v = $urandom_range(15);
              ch = (v < 10) ? 8'(48 + v) : 8'(($urandom_range(1) ? 65 : 97) + v - 10);
            end else begin
              ch = $urandom_range(1) ? 8'($urandom_range(255)) : near_hex[$urandom_range(5)];
            end
            send_req(rq(ch, j == len - 1));
            sent++;
          end
        end
      end
    end

    req_valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS repeating_key_xor_hex_codec");
    end else begin
      $display("FAIL repeating_key_xor_hex_codec");
    end
    $finish;
  end

  initial begin
    #(400_000 * 12);
    $display("FAIL repeating_key_xor_hex_codec");
    $finish;
  end

endmodule

// File: files.f
sv/rkxh_pkg.sv
sv/rkxh_cfg.sv
sv/rkxh_core.sv
sv/rkxh_obuf.sv
sv/repeating_key_xor_hex_codec.sv
sim/tb_top.sv
